// File: sv/patrol_robot_mode_controller_macros.svh
// ----------------------------------------------------------------------------
// Patrol robot mode controller assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PATROL_ROBOT_MODE_CONTROLLER_MACROS_SVH
`define PATROL_ROBOT_MODE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define PRMC_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define PRMC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: sv/prmc_pkg.sv
// ----------------------------------------------------------------------------
// Patrol robot mode controller package
// Payload structs, mode/command/light codes, register map and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package prmc_pkg;

   localparam int unsigned CSR_INDEX_W     = 3;
   localparam int unsigned CSR_DATA_W      = 16;
   localparam int unsigned BLINK_MS_DEFAULT = 400;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_SLOW   = 2'd1,
      MODE_DANGER = 2'd2,
      MODE_PATROL = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_STOP     = 2'd0,
      CMD_FORWARD  = 2'd1,
      CMD_BACKWARD = 2'd2,
      CMD_LEFT     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      LIGHT_OFF        = 3'd0,
      LIGHT_FULL_GREEN = 3'd1,
      LIGHT_HALF_GREEN = 3'd2,
      LIGHT_HALF_BLUE  = 3'd3,
      LIGHT_FULL_RED   = 3'd4
   } light_type;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DANGER_DISTANCE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_DISTANCE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKWARD_MS        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_MS            = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATROL_INTERVAL_MS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATROL_LENGTH_MS   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_SPEED       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_SPEED         = 3'd7;

   // register reset values
   localparam logic [9:0]  DANGER_DISTANCE_RST    = 10'd40;
   localparam logic [9:0]  SLOW_DISTANCE_RST      = 10'd80;
   localparam logic [15:0] BACKWARD_MS_RST        = 16'd1000;
   localparam logic [15:0] STOP_MS_RST            = 16'd2000;
   localparam logic [15:0] PATROL_INTERVAL_MS_RST = 16'd10000;
   localparam logic [15:0] PATROL_LENGTH_MS_RST   = 16'd2000;
   localparam logic [7:0]  NORMAL_SPEED_RST       = 8'd178;
   localparam logic [7:0]  SLOW_SPEED_RST         = 8'd127;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [9:0]  distance_cm;
      logic        turn_done;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] motor_command;
      logic [7:0] motor_speed;
      logic [2:0] light_pattern;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  danger_distance;
      logic [9:0]  slow_distance;
      logic [15:0] backward_ms;
      logic [15:0] stop_ms;
      logic [15:0] patrol_interval_ms;
      logic [15:0] patrol_length_ms;
      logic [7:0]  normal_speed;
      logic [7:0]  slow_speed;
   } cfg_type;

endpackage

`default_nettype wire

// File: sv/prmc_csr.sv
// ----------------------------------------------------------------------------
// Patrol robot mode controller configuration registers
// Write-only register file holding thresholds, delays and speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module prmc_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [prmc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [prmc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output prmc_pkg::cfg_type                          cfg
);

   prmc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.danger_distance    <= prmc_pkg::DANGER_DISTANCE_RST;
         cfg_ff.slow_distance      <= prmc_pkg::SLOW_DISTANCE_RST;
         cfg_ff.backward_ms        <= prmc_pkg::BACKWARD_MS_RST;
         cfg_ff.stop_ms            <= prmc_pkg::STOP_MS_RST;
         cfg_ff.patrol_interval_ms <= prmc_pkg::PATROL_INTERVAL_MS_RST;
         cfg_ff.patrol_length_ms   <= prmc_pkg::PATROL_LENGTH_MS_RST;
         cfg_ff.normal_speed       <= prmc_pkg::NORMAL_SPEED_RST;
         cfg_ff.slow_speed         <= prmc_pkg::SLOW_SPEED_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            prmc_pkg::CSR_DANGER_DISTANCE:    cfg_ff.danger_distance    <= csr_wdata[9:0];
            prmc_pkg::CSR_SLOW_DISTANCE:      cfg_ff.slow_distance      <= csr_wdata[9:0];
            prmc_pkg::CSR_BACKWARD_MS:        cfg_ff.backward_ms        <= csr_wdata;
            prmc_pkg::CSR_STOP_MS:            cfg_ff.stop_ms            <= csr_wdata;
            prmc_pkg::CSR_PATROL_INTERVAL_MS: cfg_ff.patrol_interval_ms <= csr_wdata;
            prmc_pkg::CSR_PATROL_LENGTH_MS:   cfg_ff.patrol_length_ms   <= csr_wdata;
            prmc_pkg::CSR_NORMAL_SPEED:       cfg_ff.normal_speed       <= csr_wdata[7:0];
            prmc_pkg::CSR_SLOW_SPEED:         cfg_ff.slow_speed         <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: sv/prmc_core.sv
// ----------------------------------------------------------------------------
// Patrol robot mode controller core
// Mode state and one-tick update logic; result reflects state after the tick.
// ----------------------------------------------------------------------------
`default_nettype none

module prmc_core #(
   parameter int unsigned BLINK_MS = prmc_pkg::BLINK_MS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  prmc_pkg::req_type       req,
   input  prmc_pkg::cfg_type       cfg,
   output prmc_pkg::rsp_type       rsp
);

   prmc_pkg::mode_type  mode_ff, mode_in;
   logic                entry_ff, entry_in;
   logic [31:0]         mark_ff, mark_in;
   logic [31:0]         blink_time_ff, blink_time_in;
   logic [31:0]         rev_start_ff, rev_start_in;
   logic                rev_started_ff, rev_started_in;
   logic                blink_on_ff, blink_on_in;
   prmc_pkg::cmd_type   cmd_ff, cmd_in;
   logic [7:0]          speed_ff, speed_in;
   prmc_pkg::light_type lights_ff, lights_in;

   logic [31:0]         el_mark;
   logic [31:0]         el_rev;
   logic [31:0]         el_blink;

   always_comb begin
      mode_in        = mode_ff;
      entry_in       = entry_ff;
      mark_in        = mark_ff;
      blink_time_in  = blink_time_ff;
      rev_start_in   = rev_start_ff;
      rev_started_in = rev_started_ff;
      blink_on_in    = blink_on_ff;
      cmd_in         = cmd_ff;
      speed_in       = speed_ff;
      lights_in      = lights_ff;
      el_mark        = '0;
      el_rev         = '0;
      el_blink       = '0;

      unique case (mode_ff)
         prmc_pkg::MODE_NORMAL: begin
            if (entry_ff) begin
               mark_in = req.now_ms;
            end
            entry_in  = 1'b0;
            lights_in = prmc_pkg::LIGHT_HALF_GREEN;
            speed_in  = cfg.normal_speed;
            cmd_in    = prmc_pkg::CMD_FORWARD;
            el_mark   = req.now_ms - mark_in;
            if (req.distance_cm < cfg.slow_distance) begin
               mode_in  = prmc_pkg::MODE_SLOW;
               entry_in = 1'b1;
            end
            if (el_mark >= {16'd0, cfg.patrol_interval_ms} &&
                req.distance_cm > cfg.slow_distance) begin
               mode_in  = prmc_pkg::MODE_PATROL;
               entry_in = 1'b1;
            end
         end
         prmc_pkg::MODE_SLOW: begin
            entry_in  = 1'b0;
            lights_in = prmc_pkg::LIGHT_HALF_BLUE;
            speed_in  = cfg.slow_speed;
            cmd_in    = prmc_pkg::CMD_FORWARD;
            if (req.distance_cm > cfg.slow_distance) begin
               mode_in  = prmc_pkg::MODE_NORMAL;
               entry_in = 1'b1;
            end
            // danger wins over normal
            if (req.distance_cm < cfg.danger_distance) begin
               mode_in  = prmc_pkg::MODE_DANGER;
               entry_in = 1'b1;
            end
         end
         prmc_pkg::MODE_DANGER: begin
            if (entry_ff) begin
               entry_in       = 1'b0;
               mark_in        = req.now_ms;
               rev_started_in = 1'b0;
               rev_start_in   = '0;
               cmd_in         = prmc_pkg::CMD_STOP;
               lights_in      = prmc_pkg::LIGHT_FULL_RED;
            end
            el_mark = req.now_ms - mark_in;
            el_rev  = req.now_ms - rev_start_in;
            if (el_mark >= {16'd0, cfg.stop_ms}) begin
               if (!rev_started_in) begin
                  rev_started_in = 1'b1;
                  rev_start_in   = req.now_ms;
                  speed_in       = cfg.slow_speed;
                  cmd_in         = prmc_pkg::CMD_BACKWARD;
               end else if (el_rev >= {16'd0, cfg.backward_ms}) begin
                  if (!req.turn_done) begin
                     cmd_in = prmc_pkg::CMD_LEFT;
                  end else begin
                     cmd_in = prmc_pkg::CMD_STOP;
                     if (req.distance_cm > cfg.danger_distance) begin
                        mode_in  = prmc_pkg::MODE_SLOW;
                        entry_in = 1'b1;
                     end
                  end
               end
            end
         end
         prmc_pkg::MODE_PATROL: begin
            if (entry_ff) begin
               entry_in      = 1'b0;
               blink_time_in = req.now_ms;
               mark_in       = req.now_ms;
               cmd_in        = prmc_pkg::CMD_STOP;
            end
            el_blink = req.now_ms - blink_time_in;
            el_mark  = req.now_ms - mark_in;
            if (el_blink >= 32'(BLINK_MS)) begin
               blink_on_in   = !blink_on_ff;
               blink_time_in = req.now_ms;
               lights_in     = blink_on_in ? prmc_pkg::LIGHT_FULL_GREEN : prmc_pkg::LIGHT_OFF;
               // leave only on a blink tick past the minimum pause
               if (el_mark >= {16'd0, cfg.patrol_length_ms}) begin
                  mode_in  = prmc_pkg::MODE_NORMAL;
                  entry_in = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= prmc_pkg::MODE_NORMAL;
         entry_ff       <= 1'b1;
         mark_ff        <= '0;
         blink_time_ff  <= '0;
         rev_start_ff   <= '0;
         rev_started_ff <= 1'b0;
         blink_on_ff    <= 1'b0;
         cmd_ff         <= prmc_pkg::CMD_STOP;
         speed_ff       <= '0;
         lights_ff      <= prmc_pkg::LIGHT_OFF;
      end else if (step) begin
         mode_ff        <= mode_in;
         entry_ff       <= entry_in;
         mark_ff        <= mark_in;
         blink_time_ff  <= blink_time_in;
         rev_start_ff   <= rev_start_in;
         rev_started_ff <= rev_started_in;
         blink_on_ff    <= blink_on_in;
         cmd_ff         <= cmd_in;
         speed_ff       <= speed_in;
         lights_ff      <= lights_in;
      end
   end

   assign rsp.mode          = mode_in;
   assign rsp.motor_command = cmd_in;
   assign rsp.motor_speed   = speed_in;
   assign rsp.light_pattern = lights_in;

endmodule

`default_nettype wire

// File: sv/patrol_robot_mode_controller.sv
// ----------------------------------------------------------------------------
// Patrol robot mode controller
// Input register, one-tick mode update, result register with back pressure.
// ----------------------------------------------------------------------------
// Requests wait in the input register; their responses in the result register.
// Throughput: one request per cycle; while a finished response is held by
// rsp_stall the input register takes one more request, then stalls until it moves.
// Reset (synchronous): registers to defaults, mode normal, commands stop, both
// pipeline registers empty.
`default_nettype none

module patrol_robot_mode_controller #(
   parameter int unsigned BLINK_MS = prmc_pkg::BLINK_MS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  prmc_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output prmc_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_write,
   input  wire logic [prmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [prmc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   prmc_pkg::cfg_type cfg;
   prmc_pkg::req_type req_data_ff;
   logic              req_valid_ff;
   prmc_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   prmc_pkg::rsp_type step_rsp;
   logic              step;

   // the held request steps once the result register is free or draining
   assign step      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !step;

   prmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   prmc_core #(
      .BLINK_MS (BLINK_MS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            req_valid_ff <= 1'b1;
            req_data_ff  <= req_data;
         end else if (step) begin
            req_valid_ff <= 1'b0;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= step_rsp;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: sv/prmc_checker.sv
// ----------------------------------------------------------------------------
// Patrol robot mode controller port checker
// Port-level checks on handshake, back pressure, reset and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "patrol_robot_mode_controller_macros.svh"

module prmc_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_stall,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  prmc_pkg::rsp_type                       rsp_data
);

   `PRMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled response changed")

   // the request side only backs up when the response side is stalled
   `PRMC_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall,
      rsp_valid && rsp_stall, "request stalled without response back pressure")

   `PRMC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset,
      !rsp_valid && !req_stall, "pipeline not empty after reset")

   `PRMC_ASSERT_IMPL(a_light_code, clock, reset, rsp_valid,
      rsp_data.light_pattern <= 3'(prmc_pkg::LIGHT_FULL_RED), "bad light pattern")

endmodule

bind patrol_robot_mode_controller prmc_checker u_prmc_checker (.*);

`default_nettype wire

// File: tb/patrol_robot_mode_controller_tb.sv
// ----------------------------------------------------------------------------
// Patrol robot mode controller testbench
// Drives tick requests with random idle and back pressure, predicts mode,
// motor command, speed and lights for each accepted request, and compares
// every response in order. A directed drill runs first, then random phases
// under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module patrol_robot_mode_controller_tb;

   localparam int unsigned BLINK_PERIOD_MS = prmc_pkg::BLINK_MS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned HOLD_CYCLES     = 120;
   localparam int unsigned PHASES          = 10;
   localparam int unsigned PHASE_ITEMS     = 120;
   localparam int unsigned DRILL_ROWS      = 22;

   // setting kinds of the random phases
   localparam int unsigned KIND_SMALL    = 0;
   localparam int unsigned KIND_ZERO     = 1;
   localparam int unsigned KIND_MAX      = 2;
   localparam int unsigned KIND_INVERTED = 3;
   localparam int unsigned KIND_DEFAULT  = 4;
   localparam int unsigned PHASE_KIND [PHASES] = '{
      KIND_SMALL, KIND_ZERO, KIND_SMALL, KIND_MAX, KIND_INVERTED,
      KIND_SMALL, KIND_DEFAULT, KIND_SMALL, KIND_INVERTED, KIND_SMALL
   };

   typedef struct packed {
      logic [31:0]       now_ms;
      logic [9:0]        distance_cm;
      logic              turn_done;
      logic              fixed;
      prmc_pkg::rsp_type want;
   } drill_row_type;

   localparam prmc_pkg::rsp_type CRUISE = '{prmc_pkg::MODE_NORMAL, prmc_pkg::CMD_FORWARD,
                                            prmc_pkg::NORMAL_SPEED_RST,
                                            prmc_pkg::LIGHT_HALF_GREEN};

   // default settings: patrol after 10000 ms, danger stop 2000 ms, reverse 1000 ms
   localparam drill_row_type DRILL [DRILL_ROWS] = '{
      '{32'd0,          10'd500,  1'b0, 1'b1, CRUISE},  // first tick after reset
      '{32'd9999,       10'd1023, 1'b1, 1'b1, CRUISE},  // interval not yet over
      '{32'd10000,      10'd80,   1'b0, 1'b1, CRUISE},  // equal to slow threshold
      '{32'd10001,      10'd1023, 1'b0, 1'b0, '0},      // into patrol
      '{32'd10001,      10'd0,    1'b0, 1'b0, '0},
      '{32'd10401,      10'd0,    1'b1, 1'b0, '0},      // blink on
      '{32'd12001,      10'd0,    1'b0, 1'b0, '0},      // blink off, back to normal
      '{32'd12002,      10'd79,   1'b0, 1'b0, '0},      // into slow
      '{32'd12003,      10'd40,   1'b0, 1'b0, '0},      // equal to danger threshold
      '{32'd12004,      10'd39,   1'b0, 1'b0, '0},      // into danger
      '{32'hFFFF_FF00,  10'd1023, 1'b1, 1'b0, '0},      // danger entry near wrap
      '{32'h0000_06CF,  10'd1023, 1'b0, 1'b0, '0},
      '{32'h0000_06D0,  10'd1023, 1'b0, 1'b0, '0},      // reversing
      '{32'h0000_0AB7,  10'd1023, 1'b1, 1'b0, '0},
      '{32'h0000_0AB8,  10'd1023, 1'b0, 1'b0, '0},      // turning left
      '{32'h0000_0AB9,  10'd40,   1'b1, 1'b0, '0},      // turned, distance equal
      '{32'h0000_0ABA,  10'd41,   1'b1, 1'b0, '0},      // back to slow
      '{32'h0000_0ABB,  10'd81,   1'b0, 1'b0, '0},      // back to normal
      '{32'hFFFF_FFFF,  10'd1023, 1'b0, 1'b0, '0},
      '{32'h0000_270F,  10'd1023, 1'b0, 1'b0, '0},      // interval over across wrap
      '{32'h0000_270F,  10'd512,  1'b0, 1'b0, '0},
      '{32'h0000_289F,  10'd512,  1'b1, 1'b0, '0}
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   prmc_pkg::req_type                  req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   prmc_pkg::rsp_type                  rsp_data;
   logic                               csr_write = 1'b0;
   logic [prmc_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [prmc_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   patrol_robot_mode_controller #(.BLINK_MS(BLINK_PERIOD_MS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the registers and the controller state
   prmc_pkg::cfg_type   regs;
   prmc_pkg::mode_type  cur_mode;
   bit                  entry_due;
   logic [31:0]         mark_ms, blink_ms, reverse_ms;
   bit                  reversing, blink_lit;
   prmc_pkg::cmd_type   hold_cmd;
   logic [7:0]          hold_speed;
   prmc_pkg::light_type hold_light;

   prmc_pkg::rsp_type   held_outputs_q [$];
   int unsigned         mismatches = 0;
   int unsigned         cycles = 0;
   bit                  sender_idles = 1'b1;
   bit                  receiver_idles = 1'b1;
   int unsigned         hold_requests = 0;

   function automatic void reset_controller_model();
      regs = '{prmc_pkg::DANGER_DISTANCE_RST, prmc_pkg::SLOW_DISTANCE_RST,
               prmc_pkg::BACKWARD_MS_RST, prmc_pkg::STOP_MS_RST,
               prmc_pkg::PATROL_INTERVAL_MS_RST, prmc_pkg::PATROL_LENGTH_MS_RST,
               prmc_pkg::NORMAL_SPEED_RST, prmc_pkg::SLOW_SPEED_RST};
      cur_mode   = prmc_pkg::MODE_NORMAL;
      entry_due  = 1'b1;
      mark_ms    = '0;
      blink_ms   = '0;
      reverse_ms = '0;
      reversing  = 1'b0;
      blink_lit  = 1'b0;
      hold_cmd   = prmc_pkg::CMD_STOP;
      hold_speed = '0;
      hold_light = prmc_pkg::LIGHT_OFF;
   endfunction

   function automatic void apply_register(input logic [prmc_pkg::CSR_INDEX_W-1:0] idx,
                                          input logic [prmc_pkg::CSR_DATA_W-1:0] word);
      unique case (idx)
         prmc_pkg::CSR_DANGER_DISTANCE:    regs.danger_distance    = word[9:0];
         prmc_pkg::CSR_SLOW_DISTANCE:      regs.slow_distance      = word[9:0];
         prmc_pkg::CSR_BACKWARD_MS:        regs.backward_ms        = word;
         prmc_pkg::CSR_STOP_MS:            regs.stop_ms            = word;
         prmc_pkg::CSR_PATROL_INTERVAL_MS: regs.patrol_interval_ms = word;
         prmc_pkg::CSR_PATROL_LENGTH_MS:   regs.patrol_length_ms   = word;
         prmc_pkg::CSR_NORMAL_SPEED:       regs.normal_speed       = word[7:0];
         prmc_pkg::CSR_SLOW_SPEED:         regs.slow_speed         = word[7:0];
         default: ;
      endcase
   endfunction

   function automatic void enter_mode(input prmc_pkg::mode_type m);
      cur_mode  = m;
      entry_due = 1'b1;
   endfunction

   // one tick of the controller; elapsed times wrap at 32 bits
   function automatic prmc_pkg::rsp_type predict_tick(input prmc_pkg::req_type r);
      logic [31:0]       since;
      prmc_pkg::rsp_type o;
      unique case (cur_mode)
         prmc_pkg::MODE_NORMAL: begin
            if (entry_due) begin
               entry_due = 1'b0;
               mark_ms   = r.now_ms;
            end
            hold_light = prmc_pkg::LIGHT_HALF_GREEN;
            hold_speed = regs.normal_speed;
            hold_cmd   = prmc_pkg::CMD_FORWARD;
            if (r.distance_cm < regs.slow_distance) enter_mode(prmc_pkg::MODE_SLOW);
            since = r.now_ms - mark_ms;
            if (since >= {16'd0, regs.patrol_interval_ms} &&
                r.distance_cm > regs.slow_distance) enter_mode(prmc_pkg::MODE_PATROL);
         end
         prmc_pkg::MODE_SLOW: begin
            entry_due  = 1'b0;
            hold_light = prmc_pkg::LIGHT_HALF_BLUE;
            hold_speed = regs.slow_speed;
            hold_cmd   = prmc_pkg::CMD_FORWARD;
            if (r.distance_cm > regs.slow_distance) enter_mode(prmc_pkg::MODE_NORMAL);
            // danger wins over normal
            if (r.distance_cm < regs.danger_distance) enter_mode(prmc_pkg::MODE_DANGER);
         end
         prmc_pkg::MODE_DANGER: begin
            if (entry_due) begin
               entry_due  = 1'b0;
               mark_ms    = r.now_ms;
               reversing  = 1'b0;
               reverse_ms = '0;
               hold_cmd   = prmc_pkg::CMD_STOP;
               hold_light = prmc_pkg::LIGHT_FULL_RED;
            end
            since = r.now_ms - mark_ms;
            if (since >= {16'd0, regs.stop_ms}) begin
               if (!reversing) begin
                  reversing  = 1'b1;
                  reverse_ms = r.now_ms;
                  hold_speed = regs.slow_speed;
                  hold_cmd   = prmc_pkg::CMD_BACKWARD;
               end else begin
                  since = r.now_ms - reverse_ms;
                  if (since >= {16'd0, regs.backward_ms}) begin
                     hold_cmd = prmc_pkg::CMD_LEFT;
                     if (r.turn_done) begin
                        hold_cmd = prmc_pkg::CMD_STOP;
                        if (r.distance_cm > regs.danger_distance)
                           enter_mode(prmc_pkg::MODE_SLOW);
                     end
                  end
               end
            end
         end
         default: begin
            if (entry_due) begin
               entry_due = 1'b0;
               blink_ms  = r.now_ms;
               mark_ms   = r.now_ms;
               hold_cmd  = prmc_pkg::CMD_STOP;
            end
            since = r.now_ms - blink_ms;
            if (since >= BLINK_PERIOD_MS) begin
               blink_lit  = !blink_lit;
               blink_ms   = r.now_ms;
               hold_light = blink_lit ? prmc_pkg::LIGHT_FULL_GREEN : prmc_pkg::LIGHT_OFF;
               since = r.now_ms - mark_ms;
               if (since >= {16'd0, regs.patrol_length_ms})
                  enter_mode(prmc_pkg::MODE_NORMAL);
            end
         end
      endcase
      o.mode          = cur_mode;
      o.motor_command = hold_cmd;
      o.motor_speed   = hold_speed;
      o.light_pattern = hold_light;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatches < 40)
         $display("MISMATCH %s: got %0d, wanted %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // caller is at a falling edge; valid stays high on return
   task automatic offer_request(input prmc_pkg::req_type r, input bit fixed,
                                input prmc_pkg::rsp_type want);
      prmc_pkg::rsp_type got;
      if (sender_idles)
         while ($urandom_range(0, 99) < 16) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = predict_tick(r);
      held_outputs_q.push_back(fixed ? want : got);
      @(negedge clock);
   endtask

   // lowers valid and waits for every pending response, plus pipeline latency
   task automatic drain_outputs();
      req_valid <= 1'b0;
      do @(negedge clock); while (held_outputs_q.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic load_settings(input prmc_pkg::cfg_type c);
      logic [prmc_pkg::CSR_DATA_W-1:0] words [8];
      logic [31:0]                     junk;
      junk = $urandom;
      words[prmc_pkg::CSR_DANGER_DISTANCE]    = {junk[5:0], c.danger_distance};
      words[prmc_pkg::CSR_SLOW_DISTANCE]      = {junk[11:6], c.slow_distance};
      words[prmc_pkg::CSR_BACKWARD_MS]        = c.backward_ms;
      words[prmc_pkg::CSR_STOP_MS]            = c.stop_ms;
      words[prmc_pkg::CSR_PATROL_INTERVAL_MS] = c.patrol_interval_ms;
      words[prmc_pkg::CSR_PATROL_LENGTH_MS]   = c.patrol_length_ms;
      words[prmc_pkg::CSR_NORMAL_SPEED]       = {junk[19:12], c.normal_speed};
      words[prmc_pkg::CSR_SLOW_SPEED]         = {junk[27:20], c.slow_speed};
      for (int i = 0; i < 8; i++) begin
         csr_write <= 1'b1;
         csr_index <= prmc_pkg::CSR_INDEX_W'(i);
         csr_wdata <= words[i];
         @(posedge clock);
         apply_register(prmc_pkg::CSR_INDEX_W'(i), words[i]);
         @(negedge clock);
      end
      csr_write <= 1'b0;
   endtask

   task automatic choose_settings(input int unsigned kind, output prmc_pkg::cfg_type c,
                                  output int unsigned step_limit);
      unique case (kind)
         KIND_ZERO: begin
            c = '0;
            step_limit = 150;
         end
         KIND_MAX: begin
            c = '{10'h3FF, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF};
            step_limit = 20000;
         end
         KIND_INVERTED: begin
            c.danger_distance    = 10'($urandom_range(300, 1023));
            c.slow_distance      = 10'($urandom_range(0, 200));
            c.backward_ms        = 16'($urandom_range(0, 200));
            c.stop_ms            = 16'($urandom_range(0, 200));
            c.patrol_interval_ms = 16'($urandom_range(0, 600));
            c.patrol_length_ms   = 16'($urandom_range(0, 900));
            c.normal_speed       = 8'($urandom);
            c.slow_speed         = 8'($urandom);
            step_limit = 80;
         end
         KIND_DEFAULT: begin
            c = '{prmc_pkg::DANGER_DISTANCE_RST, prmc_pkg::SLOW_DISTANCE_RST,
                  prmc_pkg::BACKWARD_MS_RST, prmc_pkg::STOP_MS_RST,
                  prmc_pkg::PATROL_INTERVAL_MS_RST, prmc_pkg::PATROL_LENGTH_MS_RST,
                  prmc_pkg::NORMAL_SPEED_RST, prmc_pkg::SLOW_SPEED_RST};
            step_limit = 1500;
         end
         default: begin
            c.danger_distance    = 10'($urandom_range(10, 60));
            c.slow_distance      = 10'($urandom_range(50, 120));
            c.backward_ms        = 16'($urandom_range(0, 300));
            c.stop_ms            = 16'($urandom_range(0, 300));
            c.patrol_interval_ms = 16'($urandom_range(0, 800));
            c.patrol_length_ms   = 16'($urandom_range(0, 1200));
            c.normal_speed       = 8'($urandom);
            c.slow_speed         = 8'($urandom);
            step_limit = 60;
         end
      endcase
   endtask

   // readings clustered around the thresholds in force
   function automatic logic [9:0] choose_reading();
      int unsigned roll, dd, sd, lo, hi;
      roll = $urandom_range(0, 99);
      dd = 32'(regs.danger_distance);
      sd = 32'(regs.slow_distance);
      lo = (dd < sd) ? dd : sd;
      hi = (dd < sd) ? sd : dd;
      if (roll < 30) return (sd == 1023) ? 10'd1023 : 10'($urandom_range(sd + 1, 1023));
      if (roll < 50) return 10'($urandom_range(lo, hi));
      if (roll < 65) return (dd == 0) ? 10'd0 : 10'($urandom_range(0, dd - 1));
      if (roll < 72) return 10'(sd);
      if (roll < 78) return 10'(dd);
      if (roll < 82) return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      return 10'($urandom_range(0, 1023));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (held_outputs_q.size() == 0) begin
            report_mismatch("response with no request pending", 32'(rsp_data), 0);
         end else begin
            prmc_pkg::rsp_type want;
            want = held_outputs_q.pop_front();
            if (rsp_data.mode != want.mode)
               report_mismatch("mode", 32'(rsp_data.mode), 32'(want.mode));
            if (rsp_data.motor_command != want.motor_command)
               report_mismatch("motor_command", 32'(rsp_data.motor_command),
                               32'(want.motor_command));
            if (rsp_data.motor_speed != want.motor_speed)
               report_mismatch("motor_speed", 32'(rsp_data.motor_speed),
                               32'(want.motor_speed));
            if (rsp_data.light_pattern != want.light_pattern)
               report_mismatch("light_pattern", 32'(rsp_data.light_pattern),
                               32'(want.light_pattern));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: random stalls plus long hold-offs on request
   initial begin
      int unsigned hold_served, hold_left;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= receiver_idles && ($urandom_range(0, 99) < 16);
         end
      end
   end

   initial begin
      prmc_pkg::req_type item;
      prmc_pkg::cfg_type settings;
      int unsigned       step_limit;
      logic [31:0]       clock_ms;
      reset_controller_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DRILL_ROWS; i++) begin
         item.now_ms      = DRILL[i].now_ms;
         item.distance_cm = DRILL[i].distance_cm;
         item.turn_done   = DRILL[i].turn_done;
         offer_request(item, DRILL[i].fixed, DRILL[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_outputs();
         choose_settings(PHASE_KIND[p], settings, step_limit);
         load_settings(settings);
         // one phase runs with no idling on either side
         sender_idles   <= (p != 2);
         receiver_idles <= (p != 2);
         clock_ms = (p % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == 30) hold_requests <= hold_requests + 1;
            if (p == 6 && n == 50) drain_outputs();
            if ($urandom_range(0, 99) < 2)
               clock_ms = $urandom;
            else
               clock_ms = clock_ms + $urandom_range(0, step_limit);
            item.now_ms      = clock_ms;
            item.distance_cm = choose_reading();
            item.turn_done   = 1'($urandom_range(0, 1));
            offer_request(item, 1'b0, '0);
         end
      end

      drain_outputs();
      repeat (6) @(negedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
